>>> src/kwm_pkg.sv
// Package of shared types, codes and defaults for the k-way sorted merge block.
package kwm_pkg;

  // Default sizes; the top level hands these down as parameters.
  localparam int unsigned LISTS_DEF      = 8;
  localparam int unsigned LIST_DEPTH_DEF = 64;

  // Fixed field widths of the request and result channels.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned LIST_NUM_W = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STATUS_W   = 3;

  // Request operation codes. The fourth code is reserved and answered as empty.
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_APPENDED = 3'd0,
    ST_POPPED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_ORDER    = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_POP_SCAN,
    S_POP_WRITE,
    S_RESULT
  } state_e;

  // One request as the sequencer sees it.
  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic [LIST_NUM_W-1:0]     list_number;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // One result as the sequencer produces it.
  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [LIST_NUM_W-1:0]     source_list;
    logic [STATUS_W-1:0]       status;
  } res_t;

endpackage

>>> src/kwm_cmd_if.sv
// Valid/ready channel interface for merge requests.
interface kwm_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [2:0]        list_number;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output list_number, output value, input ready);
  modport sink   (input valid, input opcode, input list_number, input value, output ready);
endinterface

>>> src/kwm_res_if.sv
// Valid/ready channel interface for merge results.
interface kwm_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [2:0]         source_list;
  logic [2:0]         status;

  modport source (output valid, output result_value, output source_list, output status,
                  input ready);
  modport sink   (input valid, input result_value, input source_list, input status,
                  output ready);
endinterface

>>> src/kwm_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module kwm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/kwm_ctrl.sv
// Sequencer that reads, checks and writes back the list records and the element store.
module kwm_ctrl
  import kwm_pkg::*;
#(
  parameter int unsigned LISTS      = LISTS_DEF,
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int unsigned LW  = $clog2(LISTS);
  localparam int unsigned PW  = $clog2(LIST_DEPTH);
  localparam int unsigned CW  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IW  = $clog2(LISTS + 1);
  localparam int unsigned MW  = VALUE_W + CW + PW;
  localparam int unsigned EAW = LW + PW;
  localparam int unsigned ELEM_DEPTH = LISTS * (1 << PW);

  // List record layout: newest value, fill count, read position.
  state_e                    state_q, state_d;
  cmd_t                      cmd_q, cmd_d;
  res_t                      res_q, res_d;
  logic [LISTS-1:0]          live_q, live_d;
  logic [IW-1:0]             iss_q, iss_d;
  logic                      s1_vld_q, s1_vld_d;
  logic [LW-1:0]             s1_idx_q, s1_idx_d;
  logic                      s2_vld_q, s2_vld_d;
  logic [LW-1:0]             s2_idx_q, s2_idx_d;
  logic [MW-1:0]             s2_meta_q, s2_meta_d;
  logic                      found_q, found_d;
  logic signed [VALUE_W-1:0] best_val_q, best_val_d;
  logic [LW-1:0]             best_idx_q, best_idx_d;
  logic [MW-1:0]             best_meta_q, best_meta_d;

  // Memory ports.
  logic             meta_we;
  logic [LW-1:0]    meta_waddr, meta_raddr;
  logic [MW-1:0]    meta_wdata, meta_rdata;
  logic             elem_we;
  logic [EAW-1:0]   elem_waddr, elem_raddr;
  logic [VALUE_W-1:0] elem_wdata, elem_rdata;

  // Append path signals.
  logic [LW-1:0]             a_idx;
  logic                      a_live, a_in_range, a_full, a_order;
  logic [PW-1:0]             a_pos, a_tail;
  logic [CW-1:0]             a_cnt;
  logic [PW:0]               a_sum;
  logic signed [VALUE_W-1:0] a_newest;

  // Pop path signals.
  logic [PW-1:0]             m_pos, b_pos, b_pos_next;
  logic [CW-1:0]             m_cnt, b_cnt;
  logic signed [VALUE_W-1:0] head_val;

  kwm_ram #(.WIDTH(MW), .DEPTH(LISTS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  kwm_ram #(.WIDTH(VALUE_W), .DEPTH(ELEM_DEPTH)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (elem_waddr),
    .wdata_i (elem_wdata),
    .raddr_i (elem_raddr),
    .rdata_o (elem_rdata)
  );

  // Fields of the record that was read last cycle.
  assign m_pos    = meta_rdata[PW-1:0];
  assign m_cnt    = meta_rdata[PW +: CW];
  assign a_newest = meta_rdata[PW+CW +: VALUE_W];

  // Append checks: range, fullness, order, then the tail slot with one wrap.
  assign a_idx      = LW'(cmd_q.list_number);
  assign a_in_range = 32'(cmd_q.list_number) < LISTS;
  assign a_live     = a_in_range && live_q[a_idx];
  assign a_cnt      = a_live ? m_cnt : '0;
  assign a_pos      = a_live ? m_pos : '0;
  assign a_full     = !a_in_range || (a_cnt >= CW'(LIST_DEPTH));
  assign a_order    = (a_cnt != '0) && (cmd_q.value < a_newest);
  assign a_sum      = (PW+1)'(a_pos) + (PW+1)'(a_cnt);
  assign a_tail     = (a_sum >= (PW+1)'(LIST_DEPTH)) ? PW'(a_sum - (PW+1)'(LIST_DEPTH))
                                                     : PW'(a_sum);

  // Head advance of the winning list.
  assign head_val   = elem_rdata;
  assign b_pos      = best_meta_q[PW-1:0];
  assign b_cnt      = best_meta_q[PW +: CW];
  assign b_pos_next = (b_pos == PW'(LIST_DEPTH - 1)) ? '0 : b_pos + PW'(1);

  // State and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      live_q   <= '0;
      iss_q    <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      live_q   <= live_d;
      iss_q    <= iss_d;
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    res_q       <= res_d;
    s1_idx_q    <= s1_idx_d;
    s2_idx_q    <= s2_idx_d;
    s2_meta_q   <= s2_meta_d;
    best_val_q  <= best_val_d;
    best_idx_q  <= best_idx_d;
    best_meta_q <= best_meta_d;
  end

  // Next state, memory accesses and results.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    live_d      = live_q;
    iss_d       = iss_q;
    s1_vld_d    = 1'b0;
    s1_idx_d    = s1_idx_q;
    s2_vld_d    = 1'b0;
    s2_idx_d    = s2_idx_q;
    s2_meta_d   = s2_meta_q;
    found_d     = found_q;
    best_val_d  = best_val_q;
    best_idx_d  = best_idx_q;
    best_meta_d = best_meta_q;
    meta_we     = 1'b0;
    meta_waddr  = a_idx;
    meta_wdata  = {cmd_q.value, a_cnt + CW'(1), a_pos};
    meta_raddr  = LW'(cmd_i.list_number);
    elem_we     = 1'b0;
    elem_waddr  = {a_idx, a_tail};
    elem_wdata  = cmd_q.value;
    elem_raddr  = {s1_idx_q, m_pos};
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          iss_d   = '0;
          found_d = 1'b0;
          res_d   = '{result_value: '0, source_list: '0, status: ST_EMPTY};
          case (cmd_i.opcode)
            OP_APPEND: state_d = S_APPEND;
            OP_POP:    state_d = S_POP_SCAN;
            OP_CLEAR: begin
              live_d       = '0;
              res_d.status = ST_CLEARED;
              state_d      = S_RESULT;
            end
            default: state_d = S_RESULT;
          endcase
        end
      end

      // The list record arrived; decide and write element and record.
      S_APPEND: begin
        if (a_full) begin
          res_d.status = ST_FULL;
        end else if (a_order) begin
          res_d.status = ST_ORDER;
        end else begin
          elem_we        = 1'b1;
          meta_we        = 1'b1;
          live_d[a_idx]  = 1'b1;
          res_d.status   = ST_APPENDED;
        end
        state_d = S_RESULT;
      end

      // Three-step scan: record read, head read, compare against the best so far.
      S_POP_SCAN: begin
        if (iss_q < IW'(LISTS)) begin
          meta_raddr = iss_q[LW-1:0];
          s1_vld_d   = 1'b1;
          s1_idx_d   = iss_q[LW-1:0];
          iss_d      = iss_q + IW'(1);
        end
        if (s1_vld_q) begin
          s2_vld_d  = live_q[s1_idx_q] && (m_cnt != '0);
          s2_idx_d  = s1_idx_q;
          s2_meta_d = meta_rdata;
        end
        if (s2_vld_q && (!found_q || (head_val < best_val_q))) begin
          found_d     = 1'b1;
          best_val_d  = head_val;
          best_idx_d  = s2_idx_q;
          best_meta_d = s2_meta_q;
        end
        if ((iss_q == IW'(LISTS)) && !s1_vld_q && !s2_vld_q) begin
          state_d = S_POP_WRITE;
        end
      end

      // Retire the winning head, or report that all lists are empty.
      S_POP_WRITE: begin
        if (found_q) begin
          meta_we    = 1'b1;
          meta_waddr = best_idx_q;
          meta_wdata = {best_meta_q[PW+CW +: VALUE_W], b_cnt - CW'(1), b_pos_next};
          res_d      = '{result_value: best_val_q,
                         source_list: LIST_NUM_W'(best_idx_q),
                         status: ST_POPPED};
        end
        state_d = S_RESULT;
      end

      S_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign res_o = res_q;

endmodule

>>> src/k_way_sorted_merge.sv
// Top level of the k-way sorted merge block: channels, result register and sequencer.
//
//   Channel  Direction  Carries
//   req_i    in         opcode, list_number, value
//   rsp_o    out        result_value, source_list, status
//
// An append reads the list record and decides in S_APPEND; a clear or a reserved
// code goes straight to S_RESULT. A pop scans the lists: it reads each list record and
// then its head from the registered-read memories, one list per cycle, pipelined, and
// compares each head with the best so far before S_POP_WRITE retires the winner.
// Reset clears every list at once through per-list valid bits; no clearing pass.
// The result register lets the sequencer accept the next request while a result
// waits; a stalled result holds the sequencer only when it has a new one ready.
module k_way_sorted_merge
  import kwm_pkg::*;
#(
  parameter int unsigned LISTS      = LISTS_DEF,
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  kwm_cmd_if.sink   req_i,
  kwm_res_if.source rsp_o
);

  cmd_t cmd;
  res_t res, out_q;
  logic res_valid, res_ready;
  logic out_vld_q;

  assign cmd = '{opcode: req_i.opcode, list_number: req_i.list_number, value: req_i.value};

  kwm_ctrl #(.LISTS(LISTS), .LIST_DEPTH(LIST_DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (req_i.valid),
    .cmd_ready_o (req_i.ready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Result register: loads when empty or when its result is taken.
  assign res_ready = !out_vld_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.result_value = out_q.result_value;
  assign rsp_o.source_list  = out_q.source_list;
  assign rsp_o.status       = out_q.status;

endmodule
